>>> design/sitdt_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
package sitdt_pkg;

	localparam int VALUE_W   = 32;
	localparam int DIGITS    = 10;
	localparam int DIGIT_W   = 4;
	localparam int COUNT_W   = 4;
	localparam int CHAR_W    = 6;
	localparam int POS_W     = 4;
	localparam int MAX_POS   = 10;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
	localparam logic [DIGIT_W-1:0] LAST_DIGIT = 4'd9;

	// ceil(2^35 / 10); (n * RECIP_TEN) >> 35 equals n / 10 for every 32-bit n.
	localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCCCCCD;
	localparam int                 RECIP_SHIFT = 35;

	typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

	// One item after classification: sign and magnitude.
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	// One converted item: digits least significant first, and how many there are.
	typedef struct packed {
		logic               neg;
		logic [COUNT_W-1:0] nd;
		digit_vec_t         digits;
	} job_t;

endpackage

>>> design/signed_int_to_decimal_text.sv
// Top level of the signed 32-bit integer to decimal text converter.
//
//   Channel   Handshake                  Payload
//   input     value_valid / value_stall  value[31:0], two's complement
//   output    text_valid / text_stall    character[5:0], position[3:0], is_last
//
// An accepted value passes through the front stage register and the queue; the converter then
// divides the magnitude by ten until the quotient is zero or ten digits are made (one to ten
// digits), and the emitter sends one character a cycle while the output does not stall. The
// converter works on the next item while the emitter sends. Reset clears only the valid and
// control flags. A stall on the output holds the emitter, and the queue behind it lets the
// front keep accepting until it fills.
module signed_int_to_decimal_text (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           value_valid,
	output logic                           value_stall,
	input  logic signed [31:0]             value,
	output logic                           text_valid,
	input  logic                           text_stall,
	output logic [sitdt_pkg::CHAR_W-1:0]   character,
	output logic [sitdt_pkg::POS_W-1:0]    position,
	output logic                           is_last
);

	logic             f_valid;
	logic             f_stall;
	sitdt_pkg::item_t f_item;
	logic             q_valid;
	logic             q_stall;
	sitdt_pkg::item_t q_item;
	logic             c_valid;
	logic             c_stall;
	sitdt_pkg::job_t  c_job;

	sitdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (value_valid),
		.up_stall (value_stall),
		.up_value (value),
		.dn_valid (f_valid),
		.dn_stall (f_stall),
		.dn_item  (f_item)
	);

	sitdt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (f_valid),
		.up_stall (f_stall),
		.up_item  (f_item),
		.dn_valid (q_valid),
		.dn_stall (q_stall),
		.dn_item  (q_item)
	);

	sitdt_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (q_valid),
		.up_stall (q_stall),
		.up_item  (q_item),
		.dn_valid (c_valid),
		.dn_stall (c_stall),
		.dn_job   (c_job)
	);

	sitdt_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (c_valid),
		.up_stall     (c_stall),
		.up_job       (c_job),
		.dn_valid     (text_valid),
		.dn_stall     (text_stall),
		.dn_character (character),
		.dn_position  (position),
		.dn_is_last   (is_last)
	);

	// The sign can only ever lead the text.
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && (character == sitdt_pkg::CHAR_MINUS) |-> position == '0)
		else $error("minus sign away from the first position");

	// Eleven characters is the longest text, so the eleventh must close it.
	a_longest_ends: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && (position == sitdt_pkg::POS_W'(sitdt_pkg::MAX_POS)) |-> is_last)
		else $error("text runs past eleven characters");

	// A finished digit job waiting for the emitter must hold at least one digit.
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid |-> (c_job.nd != '0) && (c_job.nd <= sitdt_pkg::COUNT_W'(sitdt_pkg::DIGITS)))
		else $error("converter produced a bad digit count");

endmodule

>>> design/sitdt_front.sv
// Front stage: takes the integer and registers its sign and magnitude.
module sitdt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            up_valid,
	output logic                            up_stall,
	input  logic [sitdt_pkg::VALUE_W-1:0]   up_value,
	output logic                            dn_valid,
	input  logic                            dn_stall,
	output sitdt_pkg::item_t                dn_item
);

	logic             valid_s1;
	sitdt_pkg::item_t item_s1;
	logic             take;

	assign up_stall = valid_s1 && dn_stall;
	assign take     = up_valid && !up_stall;
	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!dn_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// The magnitude of the most negative value wraps to 2^31, which fits unsigned.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.neg <= up_value[sitdt_pkg::VALUE_W-1];
			item_s1.mag <= up_value[sitdt_pkg::VALUE_W-1] ? (~up_value + 1'b1) : up_value;
		end
	end

endmodule

>>> design/sitdt_queue.sv
// Two-entry queue between the front stage and the converter.
module sitdt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  sitdt_pkg::item_t up_item,
	output logic             dn_valid,
	input  logic             dn_stall,
	output sitdt_pkg::item_t dn_item
);

	sitdt_pkg::item_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign up_stall = (count_q == 2'd2);
	assign dn_valid = (count_q != 2'd0);
	assign dn_item  = mem_q[rd_ptr_q];
	assign push     = up_valid && !up_stall;
	assign pop      = dn_valid && !dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= up_item;
		end
	end

endmodule

>>> design/sitdt_conv.sv
// Converter: splits the magnitude into decimal digits, one division by ten a cycle.
module sitdt_conv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  sitdt_pkg::item_t up_item,
	output logic             dn_valid,
	input  logic             dn_stall,
	output sitdt_pkg::job_t  dn_job
);

	logic                                busy_q;
	logic                                done_q;
	logic [sitdt_pkg::VALUE_W-1:0]       mag_q;
	logic                                neg_q;
	logic [sitdt_pkg::COUNT_W-1:0]       nd_q;
	sitdt_pkg::digit_vec_t               digits_q;
	logic [2*sitdt_pkg::VALUE_W-1:0]     prod;
	logic [sitdt_pkg::VALUE_W-1:0]       quot;
	logic [sitdt_pkg::DIGIT_W-1:0]       ten_quot_lo;
	logic [sitdt_pkg::DIGIT_W-1:0]       rem;
	logic                                take;
	logic                                finish;

	// Quotient by reciprocal multiply; the remainder only needs the low four bits.
	assign prod        = (2*sitdt_pkg::VALUE_W)'(mag_q) *
	                     (2*sitdt_pkg::VALUE_W)'(sitdt_pkg::RECIP_TEN);
	assign quot        = sitdt_pkg::VALUE_W'(prod >> sitdt_pkg::RECIP_SHIFT);
	assign ten_quot_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign rem         = mag_q[sitdt_pkg::DIGIT_W-1:0] - ten_quot_lo;
	assign finish      = busy_q && ((quot == '0) || (nd_q == sitdt_pkg::LAST_DIGIT));

	assign up_stall = busy_q || (done_q && dn_stall);
	assign take     = up_valid && !up_stall;
	assign dn_valid = done_q;
	assign dn_job   = '{neg: neg_q, nd: nd_q, digits: digits_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (finish) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else if (done_q && !dn_stall) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mag_q <= up_item.mag;
			neg_q <= up_item.neg;
			nd_q  <= '0;
		end else if (busy_q) begin
			digits_q[nd_q] <= rem;
			nd_q           <= nd_q + 1'b1;
			mag_q          <= quot;
		end
	end

endmodule

>>> design/sitdt_emit.sv
// Emitter: sends the sign and the digits, most significant first, through an output register.
module sitdt_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           up_valid,
	output logic                           up_stall,
	input  sitdt_pkg::job_t                up_job,
	output logic                           dn_valid,
	input  logic                           dn_stall,
	output logic [sitdt_pkg::CHAR_W-1:0]   dn_character,
	output logic [sitdt_pkg::POS_W-1:0]    dn_position,
	output logic                           dn_is_last
);

	logic                            active_q;
	logic                            sign_q;
	logic [sitdt_pkg::COUNT_W-1:0]   idx_q;
	logic [sitdt_pkg::POS_W-1:0]     pos_q;
	sitdt_pkg::digit_vec_t           digits_q;
	logic                            ovalid_q;
	logic [sitdt_pkg::CHAR_W-1:0]    ochar_q;
	logic [sitdt_pkg::POS_W-1:0]     opos_q;
	logic                            olast_q;
	logic                            take;
	logic                            adv;
	logic                            last_char;

	assign up_stall  = active_q;
	assign take      = up_valid && !active_q;
	assign adv       = active_q && (!ovalid_q || !dn_stall);
	assign last_char = !sign_q && (idx_q == '0);

	assign dn_valid     = ovalid_q;
	assign dn_character = ochar_q;
	assign dn_position  = opos_q;
	assign dn_is_last   = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
			end else if (adv && last_char) begin
				active_q <= 1'b0;
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (!dn_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sign_q   <= up_job.neg;
			idx_q    <= up_job.nd - 1'b1;
			pos_q    <= '0;
			digits_q <= up_job.digits;
		end else if (adv) begin
			pos_q <= pos_q + 1'b1;
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
		if (adv) begin
			ochar_q <= sign_q ? sitdt_pkg::CHAR_MINUS
			                  : sitdt_pkg::CHAR_ZERO + sitdt_pkg::CHAR_W'(digits_q[idx_q]);
			opos_q  <= pos_q;
			olast_q <= last_char;
		end
	end

endmodule
